>>> rtl/ati_pkg.sv
// Shared types, constants and a helper function of the adaptive tick interval block.
`timescale 1ns / 1ps
`default_nettype none
package ati_pkg;

    // Slot scheduling state codes
    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;

    // Operation codes of an input beat
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_DYNAMIC_ENABLE = 3'd0;
    localparam logic [2:0] CFG_DEFAULT_INTV   = 3'd1;
    localparam logic [2:0] CFG_MIN_INTV       = 3'd2;
    localparam logic [2:0] CFG_MAX_INTV       = 3'd3;
    localparam logic [2:0] CFG_CPU_THRESH     = 3'd4;
    localparam logic [2:0] CFG_IO_THRESH      = 3'd5;

    // Configuration reset values
    localparam logic        RST_DYNAMIC_ENABLE = 1'b1;
    localparam logic [31:0] RST_DEFAULT_INTV   = 32'd1000000;
    localparam logic [31:0] RST_MIN_INTV       = 32'd500000;
    localparam logic [31:0] RST_MAX_INTV       = 32'd2000000;
    localparam logic [13:0] RST_CPU_THRESH     = 14'd7000;
    localparam logic [13:0] RST_IO_THRESH      = 14'd5000;

    // Share arithmetic
    localparam logic [13:0] SHARE_SCALE     = 14'd10000;
    localparam logic [3:0]  SHARE_LAST_PHASE = 4'd9;
    localparam int          DIV_NUM_W = 46;
    localparam int          DIV_DEN_W = 34;

    // Input and result beats
    typedef struct packed {
        logic        operation;
        logic [5:0]  slot;
        logic [2:0]  new_state;
        logic [63:0] current_time;
    } req_t;

    typedef struct packed {
        logic [31:0] tick_number;
        logic [31:0] interval;
        logic [63:0] next_compare;
    } rsp_t;

    // One row of the slot table
    typedef struct packed {
        logic [2:0]  slot_state;
        logic [31:0] last_seen_tick;
        logic [31:0] running_total;
        logic [31:0] sleeping_total;
        logic [31:0] waiting_total;
        logic [13:0] cpu_share;
        logic [13:0] io_share;
    } row_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic set_rd;
        logic set_wr;
        logic rd;
        logic upd;
        logic sum;
        logic div_start;
        logic share_load;
        logic wr;
        logic next_slot;
        logic fsel;
        logic fmul;
        logic fdiv_start;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_ok;
        logic slot_used;
        logic recompute;
        logic last_slot;
        logic div_busy;
        logic out_busy;
    } sts_t;

    // Unsigned add that sticks at all ones on overflow
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/ati_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface ati_req_if;
    logic          valid;
    logic          ready;
    ati_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ati_rsp_if;
    logic          valid;
    logic          ready;
    ati_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ati_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ati_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ati_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ati_div #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output      logic             busy,
    output      logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic             take;

    // One shift-and-subtract step, or the operand load on start
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        take     = (shifted >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = take ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> rtl/ati_ctrl.sv
// Sequencing state machine for slot writes, the tick sweep and interval selection.
`timescale 1ns / 1ps
`default_nettype none
module ati_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_op,
    output      logic          in_ready,
    input  wire ati_pkg::sts_t sts,
    output      ati_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SET_RD = 4'd1;
    localparam logic [3:0] S_SET_WR = 4'd2;
    localparam logic [3:0] S_T_RD   = 4'd3;
    localparam logic [3:0] S_T_UPD  = 4'd4;
    localparam logic [3:0] S_T_SUM  = 4'd5;
    localparam logic [3:0] S_T_DGO  = 4'd6;
    localparam logic [3:0] S_T_DIV  = 4'd7;
    localparam logic [3:0] S_T_WR   = 4'd8;
    localparam logic [3:0] S_F_SEL  = 4'd9;
    localparam logic [3:0] S_F_MUL  = 4'd10;
    localparam logic [3:0] S_F_DGO  = 4'd11;
    localparam logic [3:0] S_F_DIV  = 4'd12;
    localparam logic [3:0] S_F_OUT  = 4'd13;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_op == ati_pkg::OP_SET) ? S_SET_RD : S_T_RD;
                end
            end
            S_SET_RD:
            begin
                if (sts.slot_ok)
                begin
                    cmd.set_rd = 1'b1;
                    state_next = S_SET_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SET_WR:
            begin
                cmd.set_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_T_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_T_UPD;
            end
            S_T_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = (sts.slot_used && sts.recompute) ? S_T_SUM : S_T_WR;
            end
            S_T_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_T_DGO;
            end
            S_T_DGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_T_DIV;
            end
            S_T_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.share_load = 1'b1;
                    state_next     = S_T_WR;
                end
            end
            S_T_WR:
            begin
                cmd.wr = 1'b1;
                if (sts.last_slot)
                begin
                    state_next = S_F_SEL;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                    state_next    = S_T_RD;
                end
            end
            S_F_SEL:
            begin
                cmd.fsel   = 1'b1;
                state_next = S_F_MUL;
            end
            S_F_MUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = S_F_DGO;
            end
            S_F_DGO:
            begin
                cmd.fdiv_start = 1'b1;
                state_next     = S_F_DIV;
            end
            S_F_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_F_OUT;
                end
            end
            S_F_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/ati_dp.sv
// Datapath: slot table, statistics update, share division and interval arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module ati_dp #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ati_pkg::cmd_t cmd,
    output      ati_pkg::sts_t sts,
    input  wire ati_pkg::req_t in_data,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          out_ready,
    output      logic          out_valid,
    output      ati_pkg::rsp_t out_data
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int ROW_W  = $bits(ati_pkg::row_t);
    localparam int NUM_W  = ati_pkg::DIV_NUM_W;
    localparam int DEN_W  = ati_pkg::DIV_DEN_W;

    // Configuration registers
    logic        dyn_reg;
    logic [31:0] def_reg, min_reg, max_reg;
    logic [13:0] cpu_thr_reg, io_thr_reg;

    // Control registers
    logic [31:0]     tick_reg;
    logic [3:0]      phase_reg;
    logic            recompute_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0] active_reg, hc_reg, hi_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic            rd_valid_reg;
    logic            out_valid_reg;

    // Payload registers
    ati_pkg::req_t   item_reg;
    ati_pkg::row_t   row_reg;
    logic [33:0]     total_reg;
    logic [NUM_W-1:0] prod_cpu_reg, prod_io_reg;
    logic [31:0]     amag_reg, base_reg;
    logic [CNT_W-1:0] bmag_reg, fden_reg;
    logic            neg_reg;
    logic [NUM_W-1:0] fprod_reg;
    ati_pkg::rsp_t   out_reg;

    // Table access
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    ati_pkg::row_t     row_rd, row_upd, row_set;
    logic [31:0]       elapsed;
    logic [SLOT_W-1:0] item_slot;

    // Divider hookup
    logic             div0_start, div1_start, div0_busy, div1_busy;
    logic [NUM_W-1:0] div0_num, div0_quo, div1_quo;
    logic [DEN_W-1:0] div0_den;

    // Interval selection
    logic signed [32:0]    diff_dm, diff_xd, a_sel;
    logic signed [CNT_W:0] act_s, hc_s, amh_s;
    logic                  case_cpu, case_io, case_idle;
    logic signed [47:0]    q_s, base_s, v_s;
    logic [31:0]           v_clamped, intv;
    logic [63:0]           next_cmp;
    logic [31:0]           tick_inc;

    assign item_slot = SLOT_W'(item_reg.slot);
    assign row_rd    = rd_valid_reg ? ati_pkg::row_t'(ram_rdata) : '0;
    assign tick_inc  = tick_reg + 32'd1;

    // Row update for one tick: charge elapsed ticks by state
    always_comb
    begin
        elapsed = tick_reg - row_rd.last_seen_tick;
        row_upd = row_rd;
        if (row_rd.slot_state != ati_pkg::ST_UNUSED)
        begin
            row_upd.last_seen_tick = tick_reg;
            case (row_rd.slot_state)
                ati_pkg::ST_RUNNING:
                    row_upd.running_total = ati_pkg::sat_add32(row_rd.running_total, elapsed);
                ati_pkg::ST_SLEEPING:
                    row_upd.sleeping_total = ati_pkg::sat_add32(row_rd.sleeping_total, elapsed);
                ati_pkg::ST_RUNNABLE:
                    row_upd.waiting_total = ati_pkg::sat_add32(row_rd.waiting_total, elapsed);
                default:
                    row_upd = row_upd;
            endcase
        end
    end

    // Row written by a set-state beat
    always_comb
    begin
        row_set            = row_rd;
        row_set.slot_state = item_reg.new_state;
        if (item_reg.new_state == ati_pkg::ST_UNUSED)
        begin
            row_set = '0;
        end
    end

    // Table ports
    assign ram_raddr = cmd.set_rd ? item_slot : idx_reg;
    assign ram_waddr = cmd.set_wr ? item_slot : idx_reg;
    assign ram_we    = cmd.set_wr || (cmd.wr && (row_reg.slot_state != ati_pkg::ST_UNUSED));
    assign ram_wdata = cmd.set_wr ? ROW_W'(row_set) : ROW_W'(row_reg);

    ati_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Dividers: unit 0 is shared between the CPU share and the interval
    assign div0_start = cmd.div_start || cmd.fdiv_start;
    assign div1_start = cmd.div_start;
    assign div0_num   = cmd.fdiv_start ? fprod_reg : prod_cpu_reg;
    assign div0_den   = cmd.fdiv_start ? DEN_W'(fden_reg) : total_reg;

    ati_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div0 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div0_start),
        .num   (div0_num),
        .den   (div0_den),
        .busy  (div0_busy),
        .quo   (div0_quo)
    );

    ati_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div1 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div1_start),
        .num   (prod_io_reg),
        .den   (total_reg),
        .busy  (div1_busy),
        .quo   (div1_quo)
    );

    // Interval case selection from the slot mix
    always_comb
    begin
        diff_dm   = $signed({1'b0, def_reg}) - $signed({1'b0, min_reg});
        diff_xd   = $signed({1'b0, max_reg}) - $signed({1'b0, def_reg});
        act_s     = $signed({1'b0, active_reg});
        hc_s      = $signed({1'b0, hc_reg});
        amh_s     = act_s - hc_s;
        case_idle = (active_reg <= CNT_W'(1));
        case_cpu  = (hc_reg > (active_reg >> 1)) && !case_idle;
        case_io   = (hi_reg > (active_reg >> 1)) && !case_idle && !case_cpu;
        a_sel     = case_io ? diff_xd : diff_dm;
    end

    // Final value with clamp
    always_comb
    begin
        q_s    = $signed(48'(div0_quo));
        base_s = $signed({16'b0, base_reg});
        v_s    = neg_reg ? (base_s - q_s) : (base_s + q_s);
        if (v_s < $signed({16'b0, min_reg}))
        begin
            v_clamped = min_reg;
        end
        else if (v_s > $signed({16'b0, 32'hFFFF_FFFF}))
        begin
            v_clamped = 32'hFFFF_FFFF;
        end
        else
        begin
            v_clamped = v_s[31:0];
        end
        intv     = dyn_reg ? v_clamped : def_reg;
        next_cmp = item_reg.current_time + 64'(intv);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dyn_reg     <= ati_pkg::RST_DYNAMIC_ENABLE;
            def_reg     <= ati_pkg::RST_DEFAULT_INTV;
            min_reg     <= ati_pkg::RST_MIN_INTV;
            max_reg     <= ati_pkg::RST_MAX_INTV;
            cpu_thr_reg <= ati_pkg::RST_CPU_THRESH;
            io_thr_reg  <= ati_pkg::RST_IO_THRESH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ati_pkg::CFG_DYNAMIC_ENABLE: dyn_reg     <= cfg_data[0];
                ati_pkg::CFG_DEFAULT_INTV:   def_reg     <= cfg_data;
                ati_pkg::CFG_MIN_INTV:       min_reg     <= cfg_data;
                ati_pkg::CFG_MAX_INTV:       max_reg     <= cfg_data;
                ati_pkg::CFG_CPU_THRESH:     cpu_thr_reg <= cfg_data[13:0];
                ati_pkg::CFG_IO_THRESH:      io_thr_reg  <= cfg_data[13:0];
                default:                     dyn_reg     <= dyn_reg;
            endcase
        end
    end

    // Tick count, sweep index, slot counts, valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            phase_reg     <= '0;
            recompute_reg <= 1'b0;
            idx_reg       <= '0;
            active_reg    <= '0;
            hc_reg        <= '0;
            hi_reg        <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[ram_raddr];
            if (cmd.accept && (in_data.operation == ati_pkg::OP_TICK))
            begin
                tick_reg   <= tick_inc;
                idx_reg    <= '0;
                active_reg <= '0;
                hc_reg     <= '0;
                hi_reg     <= '0;
                // Count ticks modulo ten; the count restarts where the tick count wraps
                if ((tick_inc == '0) || (phase_reg == ati_pkg::SHARE_LAST_PHASE))
                begin
                    phase_reg     <= '0;
                    recompute_reg <= 1'b1;
                end
                else
                begin
                    phase_reg     <= phase_reg + 4'd1;
                    recompute_reg <= 1'b0;
                end
            end
            if (cmd.next_slot)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.wr && (row_reg.slot_state != ati_pkg::ST_UNUSED))
            begin
                if ((row_reg.slot_state == ati_pkg::ST_RUNNING) ||
                    (row_reg.slot_state == ati_pkg::ST_RUNNABLE))
                begin
                    active_reg <= active_reg + 1'b1;
                end
                if (row_reg.cpu_share > cpu_thr_reg)
                begin
                    hc_reg <= hc_reg + 1'b1;
                end
                if (row_reg.io_share > io_thr_reg)
                begin
                    hi_reg <= hi_reg + 1'b1;
                end
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.upd)
        begin
            row_reg <= row_upd;
        end
        if (cmd.sum)
        begin
            total_reg    <= 34'(row_reg.running_total) + 34'(row_reg.sleeping_total)
                          + 34'(row_reg.waiting_total);
            prod_cpu_reg <= NUM_W'(row_reg.running_total) * NUM_W'(ati_pkg::SHARE_SCALE);
            prod_io_reg  <= NUM_W'(row_reg.sleeping_total) * NUM_W'(ati_pkg::SHARE_SCALE);
        end
        if (cmd.share_load && (total_reg != '0))
        begin
            row_reg.cpu_share <= div0_quo[13:0];
            row_reg.io_share  <= div1_quo[13:0];
        end
        // Operands of the chosen formula in sign and magnitude form
        if (cmd.fsel)
        begin
            amag_reg <= a_sel[32] ? 32'(-a_sel) : a_sel[31:0];
            if (case_cpu)
            begin
                bmag_reg <= amh_s[CNT_W] ? CNT_W'(-amh_s) : amh_s[CNT_W-1:0];
                neg_reg  <= a_sel[32] ^ amh_s[CNT_W];
                fden_reg <= active_reg;
                base_reg <= min_reg;
            end
            else if (case_io)
            begin
                bmag_reg <= hi_reg;
                neg_reg  <= a_sel[32];
                fden_reg <= active_reg;
                base_reg <= def_reg;
            end
            else if (case_idle)
            begin
                bmag_reg <= '0;
                neg_reg  <= 1'b0;
                fden_reg <= CNT_W'(1);
                base_reg <= max_reg;
            end
            else
            begin
                bmag_reg <= active_reg;
                neg_reg  <= !a_sel[32];
                fden_reg <= CNT_W'(SLOT_COUNT);
                base_reg <= def_reg;
            end
        end
        if (cmd.fmul)
        begin
            fprod_reg <= NUM_W'(amag_reg) * NUM_W'(bmag_reg);
        end
        if (cmd.out_load)
        begin
            out_reg.tick_number  <= tick_reg;
            out_reg.interval     <= intv;
            out_reg.next_compare <= next_cmp;
        end
    end

    // Status
    assign sts.slot_ok   = (32'(item_reg.slot) < 32'(SLOT_COUNT));
    assign sts.slot_used = (row_rd.slot_state != ati_pkg::ST_UNUSED);
    assign sts.recompute = recompute_reg;
    assign sts.last_slot = (idx_reg == SLOT_W'(SLOT_COUNT - 1));
    assign sts.div_busy  = div0_busy || div1_busy;
    assign sts.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

>>> rtl/adaptive_tick_interval.sv
// Top level of the adaptive timer tick interval selector.
`timescale 1ns / 1ps
`default_nettype none
// A set-state beat is accepted and, for a slot in range, reads the table and then
// writes it. A tick beat walks the slot table one slot at a time through a table
// memory with one read and one write port: each slot is read, updated and written
// back, and on every tenth tick two 46-step restoring dividers compute the CPU and
// I/O shares of each used slot. The interval is then formed on one of those
// dividers, and the result is loaded only once the output register is free. The
// next beat is accepted while a result still waits on the output.
// No clearing pass is needed after reset: per-slot valid bits make unwritten
// slots read as unused with zero counters.
module adaptive_tick_interval #(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ati_req_if.sink          req,
    ati_rsp_if.source        rsp,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    ati_pkg::cmd_t cmd;
    ati_pkg::sts_t sts;

    // Sequencer
    ati_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.data.operation),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    ati_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (req.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_data  (rsp.data)
    );

`ifndef ASSERT_OFF
    // A division is never started while the dividers are still working.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || cmd.fdiv_start) |-> !sts.div_busy)
        else $error("divider started while busy");

    // The block only takes a new beat when no division is in flight.
    a_ready_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !sts.div_busy)
        else $error("input ready during division");

    // A result is loaded only when the output register is free.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result overwrote a pending beat");

    // A loaded result shows as valid in the next cycle.
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

>>> bench/tb_adaptive_tick_interval.sv
// Testbench for the adaptive tick interval selector: directed and random beats checked against a predictor.
`timescale 1ns / 1ps
module tb_adaptive_tick_interval;

    localparam int NSLOT = 64;
    localparam int STALL_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    ati_req_if req_ch ();
    ati_rsp_if rsp_ch ();

    adaptive_tick_interval #(.SLOT_COUNT(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: configuration and slot table.
    logic        p_dyn;
    logic [31:0] p_dflt, p_min, p_max;
    logic [13:0] p_cpu_th, p_io_th;
    logic [31:0] p_ticks;
    logic [2:0]  p_state [NSLOT];
    logic [31:0] p_seen [NSLOT];
    logic [31:0] p_run [NSLOT];
    logic [31:0] p_slp [NSLOT];
    logic [31:0] p_wait [NSLOT];
    logic [13:0] p_cshare [NSLOT];
    logic [13:0] p_ishare [NSLOT];

    ati_pkg::req_t pending_beats[$];
    ati_pkg::rsp_t expected_results[$];
    int errors = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;
    bit hold_sender = 1'b0;
    bit req_fire = 1'b0;

    function automatic logic [31:0] add_sticky(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic reset_predictor();
        p_dyn = ati_pkg::RST_DYNAMIC_ENABLE;
        p_dflt = ati_pkg::RST_DEFAULT_INTV;
        p_min = ati_pkg::RST_MIN_INTV;
        p_max = ati_pkg::RST_MAX_INTV;
        p_cpu_th = ati_pkg::RST_CPU_THRESH;
        p_io_th = ati_pkg::RST_IO_THRESH;
        p_ticks = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            p_state[i] = ati_pkg::ST_UNUSED;
            p_seen[i] = '0; p_run[i] = '0; p_slp[i] = '0; p_wait[i] = '0;
            p_cshare[i] = '0; p_ishare[i] = '0;
        end
    endtask

    // Interval choice from the slot mix.
    function automatic logic [31:0] choose_interval();
        longint act, hc, hi, v, d, mn, mx;
        act = 0; hc = 0; hi = 0;
        d = longint'({32'd0, p_dflt});
        mn = longint'({32'd0, p_min});
        mx = longint'({32'd0, p_max});
        for (int i = 0; i < NSLOT; i++)
        begin
            if (p_state[i] == ati_pkg::ST_UNUSED) continue;
            if (p_state[i] == ati_pkg::ST_RUNNING || p_state[i] == ati_pkg::ST_RUNNABLE) act++;
            if (p_cshare[i] > p_cpu_th) hc++;
            if (p_ishare[i] > p_io_th) hi++;
        end
        if (hc > act / 2 && act > 1)
            v = mn + ((d - mn) * (act - hc)) / act;
        else if (hi > act / 2 && act > 1)
            v = d + ((mx - d) * hi) / act;
        else if (act <= 1)
            v = mx;
        else
            v = d - ((d - mn) * act) / NSLOT;
        if (v < mn) v = mn;
        if (v > 64'sh0FFFF_FFFF) v = 64'sh0FFFF_FFFF;
        return v[31:0];
    endfunction

    // Apply one accepted beat; tick beats queue a result.
    task automatic predict_beat(ati_pkg::req_t b);
        ati_pkg::rsp_t r;
        logic [31:0] el, iv;
        logic [63:0] tot;
        bit recomp;
        if (b.operation == ati_pkg::OP_SET)
        begin
            p_state[b.slot] = b.new_state;
            if (b.new_state == ati_pkg::ST_UNUSED)
            begin
                p_seen[b.slot] = '0; p_run[b.slot] = '0; p_slp[b.slot] = '0;
                p_wait[b.slot] = '0; p_cshare[b.slot] = '0; p_ishare[b.slot] = '0;
            end
            return;
        end
        p_ticks = p_ticks + 1;
        recomp = (p_ticks % 10) == 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (p_state[i] == ati_pkg::ST_UNUSED) continue;
            el = p_ticks - p_seen[i];
            if (p_state[i] == ati_pkg::ST_RUNNING) p_run[i] = add_sticky(p_run[i], el);
            else if (p_state[i] == ati_pkg::ST_SLEEPING) p_slp[i] = add_sticky(p_slp[i], el);
            else if (p_state[i] == ati_pkg::ST_RUNNABLE) p_wait[i] = add_sticky(p_wait[i], el);
            p_seen[i] = p_ticks;
            if (recomp)
            begin
                tot = 64'(p_run[i]) + 64'(p_slp[i]) + 64'(p_wait[i]);
                if (tot != 0)
                begin
                    p_cshare[i] = 14'((64'(p_run[i]) * 10000) / tot);
                    p_ishare[i] = 14'((64'(p_slp[i]) * 10000) / tot);
                end
            end
        end
        iv = p_dyn ? choose_interval() : p_dflt;
        r.tick_number = p_ticks;
        r.interval = iv;
        r.next_compare = b.current_time + 64'(iv);
        expected_results.push_back(r);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 29);
    endfunction

    // Driver: presents queued beats at the falling edge; a beat taken at the
    // last rising edge is dropped from the queue before the next is shown.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire)
        begin
            if (req_fire) void'(pending_beats.pop_front());
            if (pending_beats.size() != 0 && !hold_sender && !idle_now())
            begin
                req_ch.valid <= 1'b1;
                req_ch.data <= pending_beats[0];
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        rsp_ch.ready <= rst_n && !idle_now();

    // Monitor: accepts at the rising edge and checks results.
    always @(posedge clk)
    begin
        ati_pkg::rsp_t e;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                predict_beat(req_ch.data);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    report("unexpected result beat", 64'(rsp_ch.data.tick_number), 64'd0);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (rsp_ch.data.tick_number !== e.tick_number)
                        report("tick_number", 64'(rsp_ch.data.tick_number), 64'(e.tick_number));
                    if (rsp_ch.data.interval !== e.interval)
                        report("interval", 64'(rsp_ch.data.interval), 64'(e.interval));
                    if (rsp_ch.data.next_compare !== e.next_compare)
                        report("next_compare", rsp_ch.data.next_compare, e.next_compare);
                end
            end
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
        else
        begin
            req_fire <= 1'b0;
        end
    end

    // Watchdog on cycles with no accepted beat and no result.
    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog timeout");
            $display("tb_adaptive_tick_interval: FAIL");
            $finish;
        end
    end

    function automatic ati_pkg::req_t tick_beat(logic [63:0] t);
        ati_pkg::req_t b;
        b.operation = ati_pkg::OP_TICK;
        b.slot = 6'($urandom);
        b.new_state = 3'($urandom);
        b.current_time = t;
        return b;
    endfunction

    function automatic ati_pkg::req_t set_beat(logic [5:0] s, logic [2:0] st);
        ati_pkg::req_t b;
        b.operation = ati_pkg::OP_SET;
        b.slot = s;
        b.new_state = st;
        b.current_time = {$urandom, $urandom};
        return b;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ati_pkg::CFG_DYNAMIC_ENABLE: p_dyn = val[0];
            ati_pkg::CFG_DEFAULT_INTV: p_dflt = val;
            ati_pkg::CFG_MIN_INTV: p_min = val;
            ati_pkg::CFG_MAX_INTV: p_max = val;
            ati_pkg::CFG_CPU_THRESH: p_cpu_th = val[13:0];
            ati_pkg::CFG_IO_THRESH: p_io_th = val[13:0];
            default: ;
        endcase
    endtask

    // Wait until all beats are taken and every result is back, then let the block settle.
    task automatic drain();
        while (pending_beats.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                pending_beats.push_back(tick_beat(rand64()));
            else if (r < 90)
                pending_beats.push_back(set_beat(6'($urandom_range(11)),
                                                 3'($urandom_range(4, 2))));
            else
                pending_beats.push_back(set_beat(6'($urandom), 3'($urandom)));
        end
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        reset_predictor();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: every state code, slot extremes, time wrap, share ticks.
        for (int s = 0; s < 8; s++)
            pending_beats.push_back(set_beat(6'(s), 3'(s)));
        pending_beats.push_back(set_beat(6'd63, ati_pkg::ST_RUNNING));
        pending_beats.push_back(set_beat(6'd62, ati_pkg::ST_SLEEPING));
        pending_beats.push_back(tick_beat(64'hFFFF_FFFF_FFFF_FFFF));
        pending_beats.push_back(tick_beat(64'd0));
        for (int k = 0; k < 9; k++)
            pending_beats.push_back(tick_beat(rand64()));
        pending_beats.push_back(set_beat(6'd4, ati_pkg::ST_UNUSED));
        pending_beats.push_back(tick_beat(rand64()));
        quiet = 1'b1;
        drain();

        // Sender holds off while beats queue up, then releases them.
        hold_sender = 1'b1;
        random_phase(10);
        repeat (50) @(posedge clk);
        hold_sender = 1'b0;
        drain();
        quiet = 1'b0;

        // Settings: extremes, inverted limits, dynamic off.
        write_reg(ati_pkg::CFG_DYNAMIC_ENABLE, 32'd0);
        write_reg(ati_pkg::CFG_DEFAULT_INTV, 32'hFFFF_FFFF);
        random_phase(20);
        drain();
        write_reg(ati_pkg::CFG_DYNAMIC_ENABLE, 32'd1);
        write_reg(ati_pkg::CFG_MIN_INTV, 32'hFFFF_FFFF);
        write_reg(ati_pkg::CFG_MAX_INTV, 32'd1);
        write_reg(ati_pkg::CFG_DEFAULT_INTV, 32'd1);
        write_reg(ati_pkg::CFG_CPU_THRESH, 32'd0);
        write_reg(ati_pkg::CFG_IO_THRESH, 32'd10000);
        random_phase(30);
        drain();
        write_reg(ati_pkg::CFG_MIN_INTV, 32'd1);
        write_reg(ati_pkg::CFG_MAX_INTV, 32'hFFFF_FFFF);
        write_reg(ati_pkg::CFG_DEFAULT_INTV, 32'd3000);
        write_reg(ati_pkg::CFG_CPU_THRESH, 32'd10000);
        write_reg(ati_pkg::CFG_IO_THRESH, 32'd0);
        random_phase(30);
        drain();
        write_reg(ati_pkg::CFG_MIN_INTV, 32'($urandom_range(1000, 1)));
        write_reg(ati_pkg::CFG_DEFAULT_INTV, 32'($urandom_range(100000, 1000)));
        write_reg(ati_pkg::CFG_MAX_INTV, 32'($urandom));
        write_reg(ati_pkg::CFG_CPU_THRESH, 32'($urandom_range(10000)));
        write_reg(ati_pkg::CFG_IO_THRESH, 32'($urandom_range(10000)));
        random_phase(30);
        drain();

        if (errors == 0)
            $display("tb_adaptive_tick_interval: PASS");
        else
            $display("tb_adaptive_tick_interval: FAIL");
        $finish;
    end
endmodule
